// ===== rtl/lssd_pkg.sv =====
// lssd_pkg: shared types and constants of the range sensor reply-stream decoder.
// Used by lssd_parse and lidar_scan_stream_decoder; depends on nothing.
package lssd_pkg;

  localparam int unsigned DistW = 18;
  localparam int unsigned MinW  = 16;
  localparam int unsigned MaxW  = 18;
  localparam int unsigned CfgW  = 18;

  // Register indexes on the configuration port
  typedef enum logic {
    CFG_RANGE_MIN = 1'b0,
    CFG_RANGE_MAX = 1'b1
  } cfg_index_t;

  localparam logic [MinW-1:0] RANGE_MIN_RESET = 16'd100;
  localparam logic [MaxW-1:0] RANGE_MAX_RESET = 18'd10000;

  // Stream characters
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_M        = 8'h4D;
  localparam logic [7:0] CH_D        = 8'h44;
  localparam logic [7:0] CH_9        = 8'h39;
  localparam logic [7:0] CODE_OFFSET = 8'h30;

  // Distances at or below this are sensor error codes
  localparam logic [DistW-1:0] INVALID_LIMIT_MM = 18'd20;

  // Line numbers; data lines saturate at LINE_DATA
  localparam logic [1:0] LINE_CMD  = 2'd0;
  localparam logic [1:0] LINE_STAT = 2'd1;
  localparam logic [1:0] LINE_TIME = 2'd2;
  localparam logic [1:0] LINE_DATA = 2'd3;

  // One decoded distance
  typedef struct packed {
    logic [DistW-1:0] distance_mm;
    logic             in_range;
    logic             last;
  } result_t;

endpackage

// ===== rtl/lidar_scan_stream_decoder.sv =====
// Range sensor reply-stream decoder: one byte in per cycle unless in_stall is high,
// decoded distances out. The completing byte is decoded combinationally and its
// distance registered; a skid entry holds one result behind a stalled output.
// in_stall rises only when both output entries are full.
// Reset (rst_n low, synchronous) clears parser state and output valids and loads
// range_min_mm = 100, range_max_mm = 10000. Depends on lssd_pkg and lssd_parse.
module lidar_scan_stream_decoder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_byte_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lssd_pkg::DistW-1:0] out_distance_mm,
  output logic                       out_in_range,
  output logic                       out_last,
  input  logic                       cfg_we,
  input  lssd_pkg::cfg_index_t       cfg_index,
  input  logic [lssd_pkg::CfgW-1:0]  cfg_wdata
);

  logic [lssd_pkg::MinW-1:0] range_min_r;
  logic [lssd_pkg::MaxW-1:0] range_max_r;
  logic                      in_acc;
  logic                      res_valid;
  lssd_pkg::result_t         res;
  logic                      new_res;
  logic                      out_free;
  logic                      out_valid_r;
  logic                      skid_valid_r;
  lssd_pkg::result_t         out_data_r;
  lssd_pkg::result_t         skid_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r <= lssd_pkg::RANGE_MIN_RESET;
      range_max_r <= lssd_pkg::RANGE_MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lssd_pkg::CFG_RANGE_MIN: range_min_r <= cfg_wdata[lssd_pkg::MinW-1:0];
        lssd_pkg::CFG_RANGE_MAX: range_max_r <= cfg_wdata[lssd_pkg::MaxW-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;

  lssd_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_acc     (in_acc),
    .byte_value   (in_byte_value),
    .range_min_mm (range_min_r),
    .range_max_mm (range_max_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  assign new_res  = in_acc && res_valid;
  assign out_free = !out_valid_r || !out_stall;

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || new_res;
      skid_valid_r <= 1'b0;
    end else if (new_res) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end
    if (!out_free && new_res) begin
      skid_data_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_distance_mm = out_data_r.distance_mm;
  assign out_in_range    = out_data_r.in_range;
  assign out_last        = out_data_r.last;

`ifndef SYNTH
  // Skid entry is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while output register empty");

  // A stalled result is never dropped
  a_out_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("stalled result lost");

  // A new result behind a stalled, full output register is captured in the skid entry
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && new_res |=> skid_valid_r)
    else $error("result not captured in skid entry");

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !skid_valid_r)
    else $error("output stage not empty after reset");
`endif

endmodule

// ===== rtl/lssd_parse.sv =====
// lssd_parse: message framing, header check, checksum strip and three-character decode.
// Updates its running state once per accepted byte; depends on lssd_pkg.
module lssd_parse (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          byte_acc,
  input  logic [7:0]                    byte_value,
  input  logic [lssd_pkg::MinW-1:0]     range_min_mm,
  input  logic [lssd_pkg::MaxW-1:0]     range_max_mm,
  output logic                          res_valid,
  output lssd_pkg::result_t             res
);

  typedef struct packed {
    logic [1:0]                   line_number;
    logic [1:0]                   char_in_line;
    logic                         header_good;
    logic                         previous_was_lf;
    logic [7:0]                   pending_char;
    logic                         pending_valid;
    logic                         pending_cr;
    logic [lssd_pkg::DistW-1:0]   triple_accum;
    logic [1:0]                   triple_count;
    logic [lssd_pkg::DistW-1:0]   held_value;
    logic                         held_valid;
  } parse_state_t;

  typedef struct packed {
    parse_state_t               st;
    logic                       emit;
    logic [lssd_pkg::DistW-1:0] emit_value;
  } push_t;

  parse_state_t st_r, st_nxt;
  logic         emit;
  logic         emit_last;
  logic [lssd_pkg::DistW-1:0] emit_value;

  // Start-of-message values of the running state
  function automatic parse_state_t clear_state(input logic prev_lf);
    parse_state_t s;
    s                 = '0;
    s.header_good     = 1'b1;
    s.previous_was_lf = prev_lf;
    return s;
  endfunction

  // Feed one joined data character into the triple decoder
  function automatic push_t push_char(input push_t p, input logic [7:0] c);
    push_t      q;
    logic [7:0] code;
    q    = p;
    code = c - lssd_pkg::CODE_OFFSET;
    q.st.triple_accum = {p.st.triple_accum[lssd_pkg::DistW-7:0], code[5:0]};
    q.st.triple_count = p.st.triple_count + 2'd1;
    if (q.st.triple_count == 2'd3) begin
      if (p.st.held_valid) begin
        q.emit       = 1'b1;
        q.emit_value = p.st.held_value;
      end
      q.st.held_value   = q.st.triple_accum;
      q.st.held_valid   = 1'b1;
      q.st.triple_accum = '0;
      q.st.triple_count = 2'd0;
    end
    return q;
  endfunction

  // Push the held-back character, if any, and hold c in its place
  function automatic push_t shift_pending(input push_t p, input logic [7:0] c);
    push_t q;
    q = p;
    if (p.st.pending_valid) begin
      q = push_char(p, p.st.pending_char);
    end
    q.st.pending_char  = c;
    q.st.pending_valid = 1'b1;
    return q;
  endfunction

  // Next state and result for the byte at the input
  always_comb begin
    push_t p;
    p          = '0;
    p.st       = st_r;
    emit_last  = 1'b0;
    if (byte_value == lssd_pkg::CH_LF) begin
      if (st_r.previous_was_lf) begin
        // message end: flush held value with last mark
        p.emit       = st_r.held_valid;
        p.emit_value = st_r.held_value;
        emit_last    = 1'b1;
        p.st         = clear_state(1'b0);
      end else begin
        p.st.previous_was_lf = 1'b1;
        if ((st_r.line_number < lssd_pkg::LINE_TIME) && (st_r.char_in_line < 2'd2)) begin
          p.st.header_good = 1'b0;
        end
        p.st.pending_char  = '0;
        p.st.pending_valid = 1'b0;
        p.st.pending_cr    = 1'b0;
        p.st.char_in_line  = 2'd0;
        if (st_r.line_number != lssd_pkg::LINE_DATA) begin
          p.st.line_number = st_r.line_number + 2'd1;
        end
      end
    end else begin
      p.st.previous_was_lf = 1'b0;
      if (st_r.line_number < lssd_pkg::LINE_TIME) begin
        // header lines: check the first two characters
        if (st_r.char_in_line < 2'd2) begin
          if (st_r.line_number == lssd_pkg::LINE_CMD) begin
            if (byte_value != ((st_r.char_in_line == 2'd0) ? lssd_pkg::CH_M
                                                            : lssd_pkg::CH_D)) begin
              p.st.header_good = 1'b0;
            end
          end else if (byte_value != lssd_pkg::CH_9) begin
            p.st.header_good = 1'b0;
          end
          p.st.char_in_line = st_r.char_in_line + 2'd1;
        end
      end else if ((st_r.line_number == lssd_pkg::LINE_DATA) && st_r.header_good) begin
        // data lines: a CR not followed by LF is data
        if (st_r.pending_cr) begin
          p.st.pending_cr = 1'b0;
          p = shift_pending(p, lssd_pkg::CH_CR);
        end
        if (byte_value == lssd_pkg::CH_CR) begin
          p.st.pending_cr = 1'b1;
        end else begin
          p = shift_pending(p, byte_value);
        end
      end
    end
    st_nxt     = p.st;
    emit       = p.emit;
    emit_value = p.emit_value;
  end

  // Classify the emitted distance
  assign res_valid       = emit;
  assign res.distance_mm = emit_value;
  assign res.last        = emit_last;
  assign res.in_range    = (emit_value > lssd_pkg::INVALID_LIMIT_MM) &&
                           (emit_value >= {2'b00, range_min_mm}) &&
                           (emit_value <= range_max_mm);

  // Advance the running state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= clear_state(1'b0);
    end else if (byte_acc) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== sim/tb.sv =====
// tb: self-checking bench for lidar_scan_stream_decoder, the reply-stream distance decoder.
// Feeds byte streams of framed scans, broken frames and noise under random flow control.
// Depends on lssd_pkg and the decoder RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_BYTES   = 250;

  typedef logic [lssd_pkg::DistW-1:0] mm_t;
  typedef logic [lssd_pkg::CfgW-1:0]  cfg_word_t;

  // Ways a generated frame can be damaged
  typedef enum int {
    FLAW_NONE,
    FLAW_BAD_CMD,
    FLAW_BAD_STATUS,
    FLAW_SHORT_HDR,
    FLAW_EXTRA_LF
  } flaw_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [7:0]                 in_byte_value = 8'h00;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [lssd_pkg::DistW-1:0] out_distance_mm;
  logic                       out_in_range;
  logic                       out_last;
  logic                       cfg_we = 1'b0;
  lssd_pkg::cfg_index_t       cfg_index = lssd_pkg::CFG_RANGE_MIN;
  logic [lssd_pkg::CfgW-1:0]  cfg_wdata = '0;

  lidar_scan_stream_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_value   (in_byte_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_distance_mm (out_distance_mm),
    .out_in_range    (out_in_range),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Byte stream waiting to be sent, and expected distances waiting to come out
  logic [7:0]        byte_q [$];
  lssd_pkg::result_t awaited_distances [$];
  int                bytes_pushed = 0;
  int                bytes_taken = 0;
  int                errors = 0;

  // Decoder shadow state
  logic [lssd_pkg::MinW-1:0]  lim_min = lssd_pkg::RANGE_MIN_RESET;
  logic [lssd_pkg::MaxW-1:0]  lim_max = lssd_pkg::RANGE_MAX_RESET;
  logic [1:0]                 line_no = lssd_pkg::LINE_CMD;
  logic [1:0]                 col = 2'd0;
  logic                       hdr_ok = 1'b1;
  logic                       prev_lf = 1'b0;
  logic [7:0]                 pend_char = 8'h00;
  logic                       pend_ok = 1'b0;
  logic                       pend_cr = 1'b0;
  logic [lssd_pkg::DistW-1:0] tri_acc = '0;
  logic [1:0]                 tri_cnt = 2'd0;
  logic [lssd_pkg::DistW-1:0] held_dist = '0;
  logic                       held_ok = 1'b0;

  // Flow control state
  int   gap_left = 0;
  int   send_calm = 0;
  int   stall_left = 0;
  int   free_left = 0;
  int   stall_calm = 0;
  int   hold_left = 0;
  logic hold_start = 1'b0;

  // Known frame: range limits, inner CR, one-character data line, leftover chars;
  // then an extra line feed (empty command line) and a one-character command line
  logic [7:0] probe_bytes [$] = '{
    lssd_pkg::CH_M, lssd_pkg::CH_D, lssd_pkg::CH_LF, lssd_pkg::CH_9, lssd_pkg::CH_9,
    lssd_pkg::CH_LF, 8'h54, lssd_pkg::CH_LF,
    8'h6F, 8'h6F, 8'h6F, lssd_pkg::CH_CR, 8'h00, 8'h63, lssd_pkg::CH_CR, lssd_pkg::CH_LF,
    8'h5A, lssd_pkg::CH_CR, lssd_pkg::CH_LF,
    8'h31, 8'h32, 8'h30, 8'h30, 8'hFF, 8'h30, 8'h30, 8'h30, 8'h6B, lssd_pkg::CH_LF,
    lssd_pkg::CH_LF,
    lssd_pkg::CH_LF, lssd_pkg::CH_9, lssd_pkg::CH_9, lssd_pkg::CH_LF, 8'h54,
    lssd_pkg::CH_LF, 8'h31, 8'h32, 8'h33, 8'h34, lssd_pkg::CH_LF, lssd_pkg::CH_LF,
    lssd_pkg::CH_M, lssd_pkg::CH_LF, lssd_pkg::CH_9, lssd_pkg::CH_9, lssd_pkg::CH_LF,
    8'h54, lssd_pkg::CH_LF, 8'h35, 8'h36, 8'h37, 8'h38, lssd_pkg::CH_LF, lssd_pkg::CH_LF
  };

  // Queue one expected distance, range-checked against the current limits
  task automatic post_distance(logic [lssd_pkg::DistW-1:0] mm, logic is_final);
    lssd_pkg::result_t r;
    r.distance_mm = mm;
    r.in_range    = (mm > lssd_pkg::INVALID_LIMIT_MM) && (mm >= {2'b00, lim_min}) &&
                    (mm <= lim_max);
    r.last        = is_final;
    awaited_distances = {awaited_distances, r};
  endtask

  // Shift one 6-bit code into the current triple; a full triple replaces the held value
  task automatic shift_code(logic [7:0] c);
    logic [7:0] code;
    code    = c - lssd_pkg::CODE_OFFSET;
    tri_acc = {tri_acc[lssd_pkg::DistW-7:0], code[5:0]};
    tri_cnt = tri_cnt + 2'd1;
    if (tri_cnt == 2'd3) begin
      if (held_ok) post_distance(held_dist, 1'b0);
      held_dist = tri_acc;
      held_ok   = 1'b1;
      tri_acc   = '0;
      tri_cnt   = 2'd0;
    end
  endtask

  // Hold back one character so the checksum can be dropped at end of line
  task automatic admit_char(logic [7:0] c);
    if (pend_ok) shift_code(pend_char);
    pend_char = c;
    pend_ok   = 1'b1;
  endtask

  // Advance the shadow decoder by one accepted byte
  task automatic decode_byte(logic [7:0] b);
    logic [7:0] want;
    if (b == lssd_pkg::CH_LF) begin
      if (prev_lf) begin
        // Message end: flush held value and restart framing
        if (held_ok) post_distance(held_dist, 1'b1);
        line_no   = lssd_pkg::LINE_CMD;
        col       = 2'd0;
        hdr_ok    = 1'b1;
        pend_char = 8'h00;
        pend_ok   = 1'b0;
        pend_cr   = 1'b0;
        tri_acc   = '0;
        tri_cnt   = 2'd0;
        held_dist = '0;
        held_ok   = 1'b0;
        prev_lf   = 1'b0;
      end else begin
        prev_lf = 1'b1;
        if (line_no < lssd_pkg::LINE_TIME && col < 2'd2) hdr_ok = 1'b0;
        pend_char = 8'h00;
        pend_ok   = 1'b0;
        pend_cr   = 1'b0;
        col       = 2'd0;
        if (line_no != lssd_pkg::LINE_DATA) line_no = line_no + 2'd1;
      end
    end else begin
      prev_lf = 1'b0;
      if (line_no < lssd_pkg::LINE_TIME) begin
        if (col < 2'd2) begin
          if (line_no == lssd_pkg::LINE_CMD) begin
            want = (col == 2'd0) ? lssd_pkg::CH_M : lssd_pkg::CH_D;
          end else begin
            want = lssd_pkg::CH_9;
          end
          if (b != want) hdr_ok = 1'b0;
          col = col + 2'd1;
        end
      end else if (line_no == lssd_pkg::LINE_DATA && hdr_ok) begin
        if (pend_cr) begin
          pend_cr = 1'b0;
          admit_char(lssd_pkg::CH_CR);
        end
        if (b == lssd_pkg::CH_CR) pend_cr = 1'b1;
        else admit_char(b);
      end
    end
  endtask

  // Mostly short gaps, a few long ones, and now and then a stretch of none
  function automatic int draw_gap(ref int calm_left);
    int r;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(30, 150);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sender: account for the accepted transaction, then offer the next byte
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_byte_value);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          in_byte_value <= byte_q.pop_front();
          in_valid      <= 1'b1;
          gap_left = draw_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here once started
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: random stalls on top of any hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left != 0) begin
        stall_left--;
      end else if (free_left != 0) begin
        free_left--;
      end else begin
        stall_left = draw_gap(stall_calm);
        free_left  = $urandom_range(0, 5);
      end
      out_stall <= (stall_left != 0) || (hold_left != 0);
    end
  end

  task automatic flag_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t ns: %s", $realtime, msg);
  endtask

  // Compare each accepted distance with the oldest expectation
  always @(posedge clk) begin
    lssd_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_distances.size() == 0) begin
        flag_error($sformatf("unexpected distance %0d in_range %0b last %0b",
                             out_distance_mm, out_in_range, out_last));
      end else begin
        want = awaited_distances.pop_front();
        if (want.distance_mm != out_distance_mm || want.in_range != out_in_range ||
            want.last != out_last)
          flag_error($sformatf(
            "distance mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b (mm/in_range/last)",
            want.distance_mm, want.in_range, want.last,
            out_distance_mm, out_in_range, out_last));
      end
    end
  end

  task automatic put_byte(logic [7:0] b);
    byte_q = {byte_q, b};
    bytes_pushed++;
  endtask

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h30, 8'h7E));
    return c;
  endfunction

  // Any byte but a line feed
  function automatic logic [7:0] raw_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == lssd_pkg::CH_LF) c = lssd_pkg::CH_CR;
    return c;
  endfunction

  // Encode a 6-bit code, using any of the byte values that alias to it
  function automatic logic [7:0] code_char(logic [5:0] k);
    logic [7:0] c;
    logic [1:0] lap;
    lap = 2'($urandom_range(0, 3));
    c   = {2'b00, k} + lssd_pkg::CODE_OFFSET + {lap, 6'b0};
    if (c == lssd_pkg::CH_LF) c = {2'b00, k} + lssd_pkg::CODE_OFFSET;
    return c;
  endfunction

  // Favor distances at the validity edges
  function automatic logic [lssd_pkg::DistW-1:0] pick_distance();
    logic [lssd_pkg::DistW-1:0] v;
    case ($urandom_range(0, 9))
      0: v = mm_t'(lssd_pkg::INVALID_LIMIT_MM - 1 + $urandom_range(0, 3));
      1: v = mm_t'({2'b00, lim_min} + $urandom_range(0, 2) - 1);
      2: v = mm_t'(lim_max + $urandom_range(0, 2) - 1);
      3: v = $urandom_range(0, 1) ? '0 : '1;
      default: v = mm_t'($urandom);
    endcase
    return v;
  endfunction

  // Close a header line: some filler, maybe a CR, then the line feed
  task automatic finish_line(int filler);
    repeat (filler) put_byte(text_char());
    if ($urandom_range(0, 1)) put_byte(lssd_pkg::CH_CR);
    put_byte(lssd_pkg::CH_LF);
  endtask

  // One framed scan reply, possibly damaged
  task automatic queue_scan(int n_triples, flaw_t flaw);
    logic [7:0]                 joined [$];
    logic [lssd_pkg::DistW-1:0] v;
    int                         short_line;
    int                         span;
    int                         pos;
    short_line = $urandom_range(0, 1);
    for (int i = 0; i < n_triples; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat (3) joined = {joined, raw_char()};
      end else begin
        v = pick_distance();
        joined = {joined, code_char(v[17:12])};
        joined = {joined, code_char(v[11:6])};
        joined = {joined, code_char(v[5:0])};
      end
    end
    repeat ($urandom_range(0, 2)) joined = {joined, raw_char()};

    if (flaw == FLAW_EXTRA_LF) put_byte(lssd_pkg::CH_LF);
    put_byte(lssd_pkg::CH_M);
    if (!(flaw == FLAW_SHORT_HDR && short_line == 0))
      put_byte(flaw == FLAW_BAD_CMD ? text_char() : lssd_pkg::CH_D);
    finish_line($urandom_range(0, 2));
    put_byte(lssd_pkg::CH_9);
    if (!(flaw == FLAW_SHORT_HDR && short_line == 1))
      put_byte(flaw == FLAW_BAD_STATUS ? text_char() : lssd_pkg::CH_9);
    finish_line($urandom_range(0, 2));
    // Timestamp line needs one char, or it would end the message
    put_byte(text_char());
    finish_line($urandom_range(0, 3));

    // Split the joined data over lines, each with its checksum
    pos = 0;
    while (pos < joined.size()) begin
      span = $urandom_range(0, 24);
      for (int k = 0; k < span && pos < joined.size(); k++) begin
        put_byte(joined[pos]);
        pos++;
      end
      put_byte(text_char());
      finish_line(0);
    end
    put_byte(lssd_pkg::CH_LF);
  endtask

  task automatic queue_noise(int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) == 0) b = lssd_pkg::CH_LF;
      put_byte(b);
    end
  endtask

  // Wait until every byte is taken and every distance has come out
  task automatic settle();
    while (bytes_taken != bytes_pushed || awaited_distances.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(lssd_pkg::cfg_index_t idx, logic [lssd_pkg::CfgW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == lssd_pkg::CFG_RANGE_MIN) lim_min = val[lssd_pkg::MinW-1:0];
    else lim_max = val[lssd_pkg::MaxW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly clean frames, some damaged ones and some raw noise
  task automatic run_phase(logic squeeze);
    int first;
    int pick;
    if (squeeze) begin
      @(posedge clk);
      hold_start <= 1'b1;
      @(posedge clk);
      hold_start <= 1'b0;
    end
    first = bytes_pushed;
    while (bytes_pushed - first < PHASE_BYTES) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)
        queue_scan(($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12),
                   FLAW_NONE);
      else if (pick < 9)
        queue_scan($urandom_range(1, 8), flaw_t'($urandom_range(FLAW_BAD_CMD, FLAW_EXTRA_LF)));
      else
        queue_noise($urandom_range(1, 20));
    end
    settle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probe_bytes[i]) put_byte(probe_bytes[i]);
    settle();

    write_reg(lssd_pkg::CFG_RANGE_MIN, '0);
    write_reg(lssd_pkg::CFG_RANGE_MAX, '1);
    run_phase(1'b0);

    write_reg(lssd_pkg::CFG_RANGE_MIN, 18'h0FFFF);
    run_phase(1'b0);

    write_reg(lssd_pkg::CFG_RANGE_MIN, 18'd21);
    write_reg(lssd_pkg::CFG_RANGE_MAX, '0);
    run_phase(1'b0);

    write_reg(lssd_pkg::CFG_RANGE_MIN, cfg_word_t'($urandom_range(0, 16'hFFFF)));
    write_reg(lssd_pkg::CFG_RANGE_MAX, cfg_word_t'($urandom_range(0, 18'h3FFFF)));
    run_phase(1'b1);

    write_reg(lssd_pkg::CFG_RANGE_MIN, cfg_word_t'($urandom_range(0, 300)));
    write_reg(lssd_pkg::CFG_RANGE_MAX, cfg_word_t'($urandom_range(300, 20000)));
    run_phase(1'b0);

    write_reg(lssd_pkg::CFG_RANGE_MIN, {2'b00, lssd_pkg::RANGE_MIN_RESET});
    write_reg(lssd_pkg::CFG_RANGE_MAX, lssd_pkg::RANGE_MAX_RESET);
    run_phase(1'b0);

    if (errors == 0) begin
      $display("lidar_scan_stream_decoder test passed");
    end else begin
      $display("lidar_scan_stream_decoder test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("lidar_scan_stream_decoder test failed");
    $finish;
  end

endmodule
